// ----- rtl/core/bmprle_pkg.sv -----
// shared types and constants of the bmp rle raster decoder
package bmprle_pkg;

   // decode phase codes
   localparam logic [2:0] PH_COUNT  = 3'd0;
   localparam logic [2:0] PH_ESCAPE = 3'd1;
   localparam logic [2:0] PH_DX     = 3'd2;
   localparam logic [2:0] PH_DY     = 3'd3;
   localparam logic [2:0] PH_INDEX  = 3'd4;
   localparam logic [2:0] PH_ABS    = 3'd5;
   localparam logic [2:0] PH_PAD    = 3'd6;
   localparam logic [2:0] PH_STOP   = 3'd7;

   // escape codes following a zero count byte
   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   // result kinds
   localparam logic [1:0] KIND_SPAN = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_CLIP = 2'd2;

   // register indexes
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_NIBBLE_MODE  = 2'd2;

   localparam logic [7:0] NIB_MASK = 8'h0F;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] code_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] dest_row;
      logic [15:0] start_column;
      logic [7:0]  pixel_count;
      logic [7:0]  even_index;
      logic [7:0]  odd_index;
   } rsp_type;

endpackage

// ----- rtl/core/bmp_rle_raster_decoder.sv -----
// BMP RLE8/RLE4 raster decoder: compressed bytes in, pixel span descriptors out
//
// Takes one compressed byte per cycle and gives at most one span descriptor per byte,
// in the cycle after the byte is taken. The decode state (phase, cursor, absolute run)
// is updated in the same cycle the byte is transferred, and the result sits in a single
// output register; a new byte is taken every cycle unless that register holds a result
// that rsp_ready has not taken. Configuration (frame size, nibble mode) is written via
// the csr port while no byte is in flight, a user duty the block does not check.
// After end of bitmap or a clipped span the decoder ignores bytes until frame_start is set.
module bmp_rle_raster_decoder #(
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bmprle_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bmprle_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import bmprle_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int EW = ((CW > 16) ? CW : 16) + 1;

   // configuration registers
   logic [15:0] frame_width_ff;
   logic [15:0] frame_height_ff;
   logic        nibble_mode_ff;

   // decode state
   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] line_ff, line_in;
   logic [7:0]    run_ff, run_in;
   logic [7:0]    abs_left_ff, abs_left_in;
   logic          pad_ff, pad_in;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    has_result;

   logic req_fire;
   logic rsp_load;

   // state seen by this byte after an optional frame restart
   logic [2:0]    ph_cur;
   logic [CW-1:0] col_cur;
   logic [CW-1:0] line_cur;
   logic [7:0]    run_cur;
   logic [7:0]    abs_left_cur;
   logic          pad_cur;

   logic [7:0] b;
   logic       rle4;

   // span geometry
   logic [7:0]    span_req;
   logic [7:0]    written;
   logic [EW-1:0] col_e, line_e, fw_e, fh_e, avail_e, row_e;
   logic          line_inside, col_inside;
   logic [7:0]    even_raw, odd_raw;
   logic [1:0]    span_kind;

   // saturating adders
   logic [7:0]  col_add, line_add;
   logic [CW:0] col_sum, line_sum;
   logic [CW-1:0] col_sat, line_sat;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = req_fire && has_result;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b    = req_data.code_byte;
   assign rle4 = nibble_mode_ff;

   // restart view
   assign ph_cur       = req_data.frame_start ? PH_COUNT : phase_ff;
   assign col_cur      = req_data.frame_start ? '0 : col_ff;
   assign line_cur     = req_data.frame_start ? '0 : line_ff;
   assign run_cur      = req_data.frame_start ? 8'd0 : run_ff;
   assign abs_left_cur = req_data.frame_start ? 8'd0 : abs_left_ff;
   assign pad_cur      = req_data.frame_start ? 1'b0 : pad_ff;

   // span request length and colours
   always_comb begin
      if (ph_cur == PH_ABS) begin
         span_req = (rle4 && abs_left_cur >= 8'd2) ? 8'd2 : 8'd1;
      end else begin
         span_req = run_cur;
      end
      if (rle4) begin
         even_raw = (b >> 4) & NIB_MASK;
         odd_raw  = b & NIB_MASK;
      end else begin
         even_raw = b;
         odd_raw  = b;
      end
   end

   // clip span against the frame
   assign col_e       = EW'(col_cur);
   assign line_e      = EW'(line_cur);
   assign fw_e        = EW'(frame_width_ff);
   assign fh_e        = EW'(frame_height_ff);
   assign line_inside = line_e < fh_e;
   assign col_inside  = col_e < fw_e;
   assign avail_e     = fw_e - col_e;
   assign row_e       = fh_e - EW'(1) - line_e;

   always_comb begin
      if (!line_inside || !col_inside) begin
         written = 8'd0;
      end else if (EW'(span_req) < avail_e) begin
         written = span_req;
      end else begin
         written = avail_e[7:0];
      end
      span_kind = (written < span_req) ? KIND_CLIP : KIND_SPAN;
   end

   // saturating cursor adders
   assign col_add  = (ph_cur == PH_DX) ? b : written;
   assign line_add = (ph_cur == PH_DY) ? b : 8'd1;
   assign col_sum  = {1'b0, col_cur} + (CW+1)'(col_add);
   assign line_sum = {1'b0, line_cur} + (CW+1)'(line_add);
   assign col_sat  = col_sum[CW] ? '1 : col_sum[CW-1:0];
   assign line_sat = line_sum[CW] ? '1 : line_sum[CW-1:0];

   // decode one byte
   always_comb begin
      phase_in    = ph_cur;
      col_in      = col_cur;
      line_in     = line_cur;
      run_in      = run_cur;
      abs_left_in = abs_left_cur;
      pad_in      = pad_cur;
      has_result  = 1'b0;

      rsp_in.result_kind  = span_kind;
      rsp_in.dest_row     = line_inside ? row_e[15:0] : 16'd0;
      rsp_in.start_column = col_e[15:0];
      rsp_in.pixel_count  = written;
      rsp_in.even_index   = (written == 8'd0) ? 8'd0 : even_raw;
      rsp_in.odd_index    = (written < 8'd2) ? 8'd0 : odd_raw;

      case (ph_cur)
         PH_COUNT: begin
            if (b == 8'd0) begin
               phase_in = PH_ESCAPE;
            end else begin
               run_in   = b;
               phase_in = PH_INDEX;
            end
         end
         PH_ESCAPE: begin
            if (b == ESC_EOL) begin
               line_in  = line_sat;
               col_in   = '0;
               phase_in = PH_COUNT;
            end else if (b == ESC_EOB) begin
               phase_in   = PH_STOP;
               has_result = 1'b1;
               rsp_in     = '0;
               rsp_in.result_kind = KIND_END;
            end else if (b == ESC_DELTA) begin
               phase_in = PH_DX;
            end else begin
               abs_left_in = b;
               pad_in      = rle4 ? (b[1:0] == 2'd1 || b[1:0] == 2'd2) : b[0];
               phase_in    = PH_ABS;
            end
         end
         PH_DX: begin
            col_in   = col_sat;
            phase_in = PH_DY;
         end
         PH_DY: begin
            line_in  = line_sat;
            phase_in = PH_COUNT;
         end
         PH_INDEX: begin
            has_result = 1'b1;
            run_in     = 8'd0;
            col_in     = col_sat;
            phase_in   = (span_kind == KIND_CLIP) ? PH_STOP : PH_COUNT;
         end
         PH_ABS: begin
            has_result  = 1'b1;
            col_in      = col_sat;
            abs_left_in = (abs_left_cur > span_req) ? abs_left_cur - span_req : 8'd0;
            if (span_kind == KIND_CLIP) begin
               phase_in = PH_STOP;
            end else if (abs_left_in == 8'd0) begin
               phase_in = pad_cur ? PH_PAD : PH_COUNT;
            end
         end
         PH_PAD: begin
            pad_in   = 1'b0;
            phase_in = PH_COUNT;
         end
         default: begin
            phase_in = ph_cur;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 16'd1;
         frame_height_ff <= 16'd1;
         nibble_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            REG_NIBBLE_MODE:  nibble_mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // decode state update on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         col_ff      <= '0;
         line_ff     <= '0;
         run_ff      <= 8'd0;
         abs_left_ff <= 8'd0;
         pad_ff      <= 1'b0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         col_ff      <= col_in;
         line_ff     <= line_in;
         run_ff      <= run_in;
         abs_left_ff <= abs_left_in;
         pad_ff      <= pad_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // a clip or end of bitmap leaves the decoder stopped
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_in.result_kind != KIND_SPAN |=> phase_ff == PH_STOP)
      else $error("decoder not stopped after end or clip");

   // a stopped decoder gives no result without a frame restart
   assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_STOP && !req_data.frame_start |-> !rsp_load)
      else $error("result produced while stopped");

   // end of bitmap carries no pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_kind == KIND_END |-> rsp_ff.pixel_count == 8'd0)
      else $error("end of bitmap with pixels");

   // absolute spans never exceed two pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && ph_cur == PH_ABS |-> rsp_in.pixel_count <= 8'd2)
      else $error("absolute span too long");

endmodule

// ----- test/tb_bmp_rle_raster_decoder.sv -----
// testbench of the bmp rle raster decoder: byte stream stimulus, span prediction, checking
module tb_bmp_rle_raster_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bmprle_pkg::*;

   // leading zero of every escape sequence
   localparam logic [7:0] ESC_LEAD = 8'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_FRAME_WIDTH;
   logic [15:0] csr_wdata = '0;

   // frame settings as last written
   logic [15:0] cfg_width = 16'd1;
   logic [15:0] cfg_height = 16'd1;
   logic        cfg_rle4 = 1'b0;

   // decoder state as predicted
   logic [2:0]  dec_phase = PH_COUNT;
   logic [15:0] cur_col = '0;
   logic [15:0] cur_line = '0;
   logic [7:0]  run_len = '0;
   logic [7:0]  abs_left = '0;
   logic        pad_due = 1'b0;

   rsp_type     expected_spans[$];
   int          fail_count = 0;
   int          live_bytes = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   bmp_rle_raster_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // coordinate add, saturating at the top of the range
   function automatic logic [15:0] coord_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // result descriptor with unused index fields zeroed
   function automatic rsp_type pack_result(input logic [1:0] kind, input logic [15:0] row,
         input logic [15:0] col, input logic [7:0] count, input logic [7:0] even,
         input logic [7:0] odd);
      rsp_type r;
      r.result_kind  = kind;
      r.dest_row     = row;
      r.start_column = col;
      r.pixel_count  = count;
      r.even_index   = (count == 8'd0) ? 8'd0 : even;
      r.odd_index    = (count < 8'd2) ? 8'd0 : odd;
      return r;
   endfunction

   // span at the cursor, clipped to the frame; a cut span stops the decoder
   function automatic rsp_type paint_span(input logic [7:0] want, input logic [7:0] even,
         input logic [7:0] odd);
      logic [15:0] row;
      logic [15:0] room;
      logic [7:0]  done;
      logic [1:0]  kind;
      row  = '0;
      done = '0;
      if (cur_line < cfg_height) begin
         row = cfg_height - 16'd1 - cur_line;
         if (cur_col < cfg_width) begin
            room = cfg_width - cur_col;
            done = ({8'd0, want} < room) ? want : room[7:0];
         end
      end
      kind = (done < want) ? KIND_CLIP : KIND_SPAN;
      paint_span = pack_result(kind, row, cur_col, done, even, odd);
      cur_col = coord_add(cur_col, {8'd0, done});
      if (kind == KIND_CLIP) dec_phase = PH_STOP;
   endfunction

   // advance the decoder by one byte, giving the span descriptor it causes
   function automatic void decode_byte(input req_type item, output bit has_rsp,
         output rsp_type res);
      logic [7:0] b;
      logic [7:0] want;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       rle4;
      b       = item.code_byte;
      rle4    = cfg_rle4;
      has_rsp = 1'b0;
      res     = '0;
      hi      = rle4 ? ((b >> 4) & NIB_MASK) : b;
      lo      = rle4 ? (b & NIB_MASK) : b;
      if (item.frame_start) begin
         dec_phase = PH_COUNT;
         cur_col   = '0;
         cur_line  = '0;
         run_len   = '0;
         abs_left  = '0;
         pad_due   = 1'b0;
      end
      case (dec_phase)
         PH_COUNT: begin
            if (b == ESC_LEAD) begin
               dec_phase = PH_ESCAPE;
            end else begin
               run_len   = b;
               dec_phase = PH_INDEX;
            end
         end
         PH_ESCAPE: begin
            case (b)
               ESC_EOL: begin
                  cur_line  = coord_add(cur_line, 16'd1);
                  cur_col   = '0;
                  dec_phase = PH_COUNT;
               end
               ESC_EOB: begin
                  dec_phase = PH_STOP;
                  has_rsp   = 1'b1;
                  res       = pack_result(KIND_END, '0, '0, '0, '0, '0);
               end
               ESC_DELTA: dec_phase = PH_DX;
               default: begin
                  abs_left  = b;
                  pad_due   = rle4 ? (b[1:0] == 2'd1 || b[1:0] == 2'd2) : b[0];
                  dec_phase = PH_ABS;
               end
            endcase
         end
         PH_DX: begin
            cur_col   = coord_add(cur_col, {8'd0, b});
            dec_phase = PH_DY;
         end
         PH_DY: begin
            cur_line  = coord_add(cur_line, {8'd0, b});
            dec_phase = PH_COUNT;
         end
         PH_INDEX: begin
            want      = run_len;
            run_len   = '0;
            dec_phase = PH_COUNT;
            has_rsp   = 1'b1;
            res       = paint_span(want, hi, lo);
         end
         PH_ABS: begin
            want     = (rle4 && abs_left >= 8'd2) ? 8'd2 : 8'd1;
            abs_left = (abs_left > want) ? abs_left - want : 8'd0;
            if (abs_left == 8'd0) dec_phase = pad_due ? PH_PAD : PH_COUNT;
            has_rsp  = 1'b1;
            res      = paint_span(want, hi, lo);
         end
         PH_PAD: begin
            pad_due   = 1'b0;
            dec_phase = PH_COUNT;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result side: check each transfer against the oldest expectation, stall at random
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_spans.size() == 0) begin
            $error("result_kind: expected none, actual %0d", rsp_data.result_kind);
            fail_count++;
         end else begin
            want = expected_spans.pop_front();
            check_field("result_kind", want.result_kind, rsp_data.result_kind);
            check_field("dest_row", want.dest_row, rsp_data.dest_row);
            check_field("start_column", want.start_column, rsp_data.start_column);
            check_field("pixel_count", want.pixel_count, rsp_data.pixel_count);
            check_field("even_index", want.even_index, rsp_data.even_index);
            check_field("odd_index", want.odd_index, rsp_data.odd_index);
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // one byte transfer, with a random gap before it
   task automatic send_byte(input logic fs, input logic [7:0] b);
      req_type item;
      rsp_type res;
      bit      has_rsp;
      item.frame_start = fs;
      item.code_byte   = b;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (fs || dec_phase != PH_STOP) live_bytes++;
      decode_byte(item, has_rsp, res);
      if (has_rsp) expected_spans.push_back(res);
   endtask

   // stop sending and let every expected result arrive
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_spans.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:  cfg_width = val;
         REG_FRAME_HEIGHT: cfg_height = val;
         REG_NIBBLE_MODE:  cfg_rle4 = val[0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic rle4);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_NIBBLE_MODE, {15'd0, rle4});
      csr_we <= 1'b0;
   endtask

   // settings after reset: one pixel frame, second pixel clips, then bytes are ignored
   task automatic test_reset_defaults();
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'hAB);
      send_byte(1'b0, 8'd2);
      send_byte(1'b0, 8'h5A);
      send_byte(1'b0, ESC_LEAD);
      wait_idle();
   endtask

   // encoded runs in both pixel modes, longest and shortest counts
   task automatic test_encoded_runs();
      set_frame(16'd300, 16'd20, 1'b0);
      send_byte(1'b1, 8'd255);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'h00);
      wait_idle();
      set_frame(16'd300, 16'd20, 1'b1);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, 8'hA5);
      send_byte(1'b0, 8'd2);
      send_byte(1'b0, 8'h0F);
      wait_idle();
   endtask

   // absolute runs with and without the word pad
   task automatic test_absolute_runs();
      set_frame(16'd300, 16'd20, 1'b0);
      send_byte(1'b1, ESC_LEAD);
      send_byte(1'b0, 8'd3);
      send_byte(1'b0, 8'h10);
      send_byte(1'b0, 8'h20);
      send_byte(1'b0, 8'h30);
      send_byte(1'b0, 8'hEE);
      wait_idle();
      set_frame(16'd300, 16'd20, 1'b1);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, 8'h12);
      send_byte(1'b0, 8'h34);
      send_byte(1'b0, 8'h56);
      send_byte(1'b0, 8'hEE);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, 8'd4);
      send_byte(1'b0, 8'h9A);
      send_byte(1'b0, 8'hBC);
      wait_idle();
   endtask

   // end of line, delta, end of bitmap and restarts
   task automatic test_line_control();
      set_frame(16'd64, 16'd8, 1'b0);
      send_byte(1'b1, ESC_LEAD);
      send_byte(1'b0, ESC_EOL);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, ESC_DELTA);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'd3);
      send_byte(1'b0, 8'h77);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, ESC_EOB);
      send_byte(1'b0, 8'h42);
      // restart in the middle of an escape
      send_byte(1'b1, ESC_LEAD);
      send_byte(1'b1, 8'd4);
      send_byte(1'b0, 8'h09);
      wait_idle();
   endtask

   // spans that fill, cross or miss the frame
   task automatic test_clipping();
      set_frame(16'd10, 16'd2, 1'b0);
      send_byte(1'b1, 8'd10);
      send_byte(1'b0, 8'h11);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, ESC_EOL);
      send_byte(1'b0, 8'd8);
      send_byte(1'b0, 8'h22);
      send_byte(1'b0, ESC_LEAD);
      send_byte(1'b0, 8'd3);
      send_byte(1'b0, 8'hA1);
      send_byte(1'b0, 8'hA2);
      send_byte(1'b0, 8'hA3);
      send_byte(1'b0, 8'hA4);
      // line above the frame
      send_byte(1'b1, ESC_LEAD);
      send_byte(1'b0, ESC_DELTA);
      send_byte(1'b0, 8'd0);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, 8'd1);
      send_byte(1'b0, 8'h33);
      // run longer than the row
      send_byte(1'b1, 8'd12);
      send_byte(1'b0, 8'h44);
      wait_idle();
   endtask

   // pixel mode switched while an absolute run is open
   task automatic test_mode_switch_mid_run();
      set_frame(16'd64, 16'd8, 1'b0);
      send_byte(1'b1, ESC_LEAD);
      send_byte(1'b0, 8'd5);
      send_byte(1'b0, 8'h11);
      send_byte(1'b0, 8'h22);
      wait_idle();
      set_frame(16'd64, 16'd8, 1'b1);
      send_byte(1'b0, 8'h33);
      send_byte(1'b0, 8'h44);
      send_byte(1'b0, 8'h55);
      send_byte(1'b0, 8'd2);
      send_byte(1'b0, 8'h66);
      wait_idle();
   endtask

   // random raster: mostly well-formed sequences, some noise and restarts
   task automatic run_raster(input int target);
      int   stop_at;
      int   choice;
      int   n;
      logic fs;
      stop_at = live_bytes + target;
      while (live_bytes < stop_at) begin
         fs     = (dec_phase == PH_STOP) || ($urandom_range(99) < 3);
         choice = $urandom_range(99);
         if (choice < 40) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
            send_byte(fs, 8'(n));
            send_byte(1'b0, 8'($urandom_range(255)));
         end else if (choice < 62) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            send_byte(fs, ESC_LEAD);
            send_byte(1'b0, 8'(n));
            repeat (cfg_rle4 ? (n + 1) / 2 : n) send_byte(1'b0, 8'($urandom_range(255)));
            if (cfg_rle4 ? (n % 4 == 1 || n % 4 == 2) : (n % 2 == 1))
               send_byte(1'b0, 8'($urandom_range(255)));
         end else if (choice < 72) begin
            send_byte(fs, ESC_LEAD);
            send_byte(1'b0, ESC_EOL);
         end else if (choice < 80) begin
            send_byte(fs, ESC_LEAD);
            send_byte(1'b0, ESC_DELTA);
            send_byte(1'b0, 8'(($urandom_range(5) == 0) ? $urandom_range(255)
                                                         : $urandom_range(16)));
            send_byte(1'b0, 8'(($urandom_range(5) == 0) ? $urandom_range(255)
                                                         : $urandom_range(3)));
         end else if (choice < 84) begin
            send_byte(fs, ESC_LEAD);
            send_byte(1'b0, ESC_EOB);
            repeat ($urandom_range(2)) send_byte(1'b0, 8'($urandom_range(255)));
         end else begin
            send_byte(fs || ($urandom_range(9) == 0), 8'($urandom_range(255)));
         end
      end
   endtask

   // random traffic under each idling pattern, frame changed halfway
   task automatic test_random_traffic();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         repeat (2) begin
            wait_idle();
            set_frame(16'(($urandom_range(4) == 0) ? $urandom_range(1, 8)
                                                    : $urandom_range(16, 320)),
                      16'($urandom_range(2, 40)), 1'($urandom_range(1)));
            run_raster(40);
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_encoded_runs();
      test_absolute_runs();
      test_line_control();
      test_clipping();
      test_mode_switch_mid_run();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
